@@ hdl/bim_pkg.sv @@
package bim_pkg;

	localparam int LIMB_W    = 64;
	localparam int HALF_W    = LIMB_W / 2;
	localparam int LIMBS_DEF = 16;

	typedef enum logic [6:0] {
		ST_LOAD     = 7'b0000001,
		ST_MAC      = 7'b0000010,
		ST_DRAIN    = 7'b0000100,
		ST_CARRY    = 7'b0001000,
		ST_OUT_RD   = 7'b0010000,
		ST_OUT_LD   = 7'b0100000,
		ST_OUT_WAIT = 7'b1000000
	} state_t;

endpackage

@@ hdl/big_integer_multiply_core.sv @@
// Schoolbook multiplier for two unsigned integers of LIMBS 64-bit limbs each.
//
// Input channel (in_valid/in_ready): one limb of each operand per transfer,
// least significant first. The transfer with last_limb set ends the load and
// starts the multiply; limbs not delivered count as zero, limbs beyond LIMBS
// are dropped. in_ready is high only while the block is loading.
// Output channel (out_valid/out_ready): the low LIMBS product limbs, least
// significant first; last_result marks the final limb and overflow is set on
// it if any higher product limb is nonzero.
// Loading accepts one limb per transfer. The multiply runs one row of
// LIMBS multiply-accumulates per outer limb through a single 64x64 multiplier
// (four 32x32 partial products) and the accumulator memory's read and write
// ports; each row passes through ST_MAC, ST_DRAIN and ST_CARRY. Each result
// limb then passes through memory read, output register and transfer
// (ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT).
// A stalled receiver holds the output register; nothing else moves meanwhile.
// Reset clears the load count and the pipeline; the accumulator needs no
// clearing since each row reads only entries that earlier rows wrote, and the first row ignores what it reads.
module big_integer_multiply_core
	import bim_pkg::*;
#(
	parameter int LIMBS = LIMBS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [LIMB_W-1:0] a_limb,
	input  logic [LIMB_W-1:0] b_limb,
	input  logic              last_limb,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [LIMB_W-1:0] product_limb,
	output logic              last_result,
	output logic              overflow
);

	localparam int IW = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int CW = $clog2(LIMBS + 1);
	localparam int AW = $clog2(2 * LIMBS);

	state_t state_q;

	logic [LIMB_W-1:0] a_mem [LIMBS];
	logic [LIMB_W-1:0] b_mem [LIMBS];
	logic [LIMB_W-1:0] acc_mem [2*LIMBS];

	logic [LIMB_W-1:0] a_rd_q, b_rd_q, acc_rd_q;
	logic [AW-1:0]     acc_raddr;
	logic              acc_we;
	logic [AW-1:0]     acc_waddr;
	logic [LIMB_W-1:0] acc_wdata;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [LIMB_W-1:0] carry_q;
	logic          ovf_q;

	logic          v_s1, v_s2, v_s3;
	logic          a_ok_s1, b_ok_s1, first_s1;
	logic          rlast_s1, rlast_s2, rlast_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [LIMB_W-1:0] pp00_s2, pp01_s2, pp10_s2, pp11_s2, acc_s2;
	logic [2*LIMB_W-1:0] prod_s3;
	logic [LIMB_W-1:0]   acc_s3;

	logic [LIMB_W-1:0]   a_op, b_op;
	logic [2*LIMB_W-1:0] sum;
	logic                in_xfer, out_xfer, row_last, j_last;

	logic [LIMB_W-1:0] out_data_q;
	logic              out_valid_q, out_last_q, out_ovf_q;

	assign in_ready     = (state_q == ST_LOAD);
	assign in_xfer      = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign out_xfer     = out_valid_q && out_ready;
	assign product_limb = out_data_q;
	assign last_result  = out_last_q;
	assign overflow     = out_ovf_q;

	assign row_last = (i_q == IW'(LIMBS - 1));
	assign j_last   = (j_q == IW'(LIMBS - 1));

	always_comb begin
		if (state_q == ST_MAC) begin
			acc_raddr = AW'(i_q) + AW'(j_q);
		end else begin
			acc_raddr = AW'(k_q);
		end
	end

	// operand stores
	always_ff @(posedge clk) begin
		if (in_xfer && (cnt_q < CW'(LIMBS))) begin
			a_mem[cnt_q[IW-1:0]] <= a_limb;
			b_mem[cnt_q[IW-1:0]] <= b_limb;
		end
		a_rd_q <= a_mem[j_q];
		b_rd_q <= b_mem[i_q];
	end

	// accumulator
	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// stage 1: masked operands into partial products
	assign a_op = a_ok_s1 ? a_rd_q : '0;
	assign b_op = b_ok_s1 ? b_rd_q : '0;

	always_ff @(posedge clk) begin
		pp00_s2  <= a_op[HALF_W-1:0] * b_op[HALF_W-1:0];
		pp01_s2  <= a_op[HALF_W-1:0] * b_op[LIMB_W-1:HALF_W];
		pp10_s2  <= a_op[LIMB_W-1:HALF_W] * b_op[HALF_W-1:0];
		pp11_s2  <= a_op[LIMB_W-1:HALF_W] * b_op[LIMB_W-1:HALF_W];
		acc_s2   <= first_s1 ? '0 : acc_rd_q;
		idx_s2   <= idx_s1;
		rlast_s2 <= rlast_s1;
		// stage 2: full 128-bit product
		prod_s3  <= {{LIMB_W{1'b0}}, pp00_s2}
			+ ({{LIMB_W{1'b0}}, pp01_s2} << HALF_W)
			+ ({{LIMB_W{1'b0}}, pp10_s2} << HALF_W)
			+ {pp11_s2, {LIMB_W{1'b0}}};
		acc_s3   <= acc_s2;
		idx_s3   <= idx_s2;
		rlast_s3 <= rlast_s2;
	end

	// stage 3: accumulate with running carry
	assign sum = prod_s3 + {{LIMB_W{1'b0}}, acc_s3} + {{LIMB_W{1'b0}}, carry_q};

	always_comb begin
		acc_we    = 1'b0;
		acc_waddr = idx_s3;
		acc_wdata = sum[LIMB_W-1:0];
		if (v_s3) begin
			acc_we = 1'b1;
		end else if (state_q == ST_CARRY) begin
			acc_we    = 1'b1;
			acc_waddr = AW'(i_q) + AW'(LIMBS);
			acc_wdata = carry_q;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= AW'(i_q) + AW'(j_q);
		a_ok_s1  <= (CW'(j_q) < cnt_q);
		b_ok_s1  <= (CW'(i_q) < cnt_q);
		first_s1 <= (i_q == '0);
		rlast_s1 <= row_last;
		if (state_q == ST_OUT_LD) begin
			out_data_q <= acc_rd_q;
			out_last_q <= (k_q == IW'(LIMBS - 1));
			out_ovf_q  <= (k_q == IW'(LIMBS - 1)) && ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			carry_q     <= '0;
			ovf_q       <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				carry_q <= sum[2*LIMB_W-1:LIMB_W];
				if (rlast_s3 && (idx_s3 >= AW'(LIMBS)) && (sum[LIMB_W-1:0] != '0)) begin
					ovf_q <= 1'b1;
				end
			end
			case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (cnt_q < CW'(LIMBS)) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (last_limb) begin
							i_q     <= '0;
							j_q     <= '0;
							ovf_q   <= 1'b0;
							carry_q <= '0;
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					if (j_last) begin
						j_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_CARRY;
					end
				end
				ST_CARRY: begin
					carry_q <= '0;
					if (row_last && (carry_q != '0)) begin
						ovf_q <= 1'b1;
					end
					if (row_last) begin
						k_q     <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= ST_MAC;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (out_xfer) begin
						out_valid_q <= 1'b0;
						if (k_q == IW'(LIMBS - 1)) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IW'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// loading and result delivery never overlap
	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input accepted while a result is pending");

	// mac pipeline is empty while loading
	a_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("mac pipeline busy while loading");

	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> last_result)
		else $error("overflow flagged on a non-final limb");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LIMBS))
		else $error("load count beyond limb count");

	// the carry word is only written back once the row has drained
	a_carry_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CARRY) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("carry write overlaps accumulate");

endmodule
